/* rtl/bss_pkg.sv */
// Shared constants, types and codes for the BMP stream serializer.
`default_nettype none

package bss_pkg;

  // Default dimension register width.
  localparam int DIM_BITS_DEF = 14;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Register reset values.
  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;

  // Header layout.
  localparam int FILE_HDR_LEN = 14;
  localparam int INFO_HDR_LEN = 40;
  localparam int HDR_LEN      = FILE_HDR_LEN + INFO_HDR_LEN;
  localparam int HDR_IDX_BITS = $clog2(HDR_LEN);
  localparam logic [HDR_IDX_BITS-1:0] HDR_IDX_LAST = HDR_IDX_BITS'(HDR_LEN - 1);

  localparam logic [HDR_IDX_BITS-1:0] OFS_SIG_B  = HDR_IDX_BITS'(0);
  localparam logic [HDR_IDX_BITS-1:0] OFS_SIG_M  = HDR_IDX_BITS'(1);
  localparam logic [HDR_IDX_BITS-1:0] OFS_SIZE   = HDR_IDX_BITS'(2);
  localparam logic [HDR_IDX_BITS-1:0] OFS_OFFSET = HDR_IDX_BITS'(10);
  localparam logic [HDR_IDX_BITS-1:0] OFS_INFO   = HDR_IDX_BITS'(14);
  localparam logic [HDR_IDX_BITS-1:0] OFS_WIDTH  = HDR_IDX_BITS'(18);
  localparam logic [HDR_IDX_BITS-1:0] OFS_HEIGHT = HDR_IDX_BITS'(22);
  localparam logic [HDR_IDX_BITS-1:0] OFS_PLANES = HDR_IDX_BITS'(26);
  localparam logic [HDR_IDX_BITS-1:0] OFS_BPP    = HDR_IDX_BITS'(28);

  localparam logic [7:0] SIG_B      = 8'h42;  // 'B'
  localparam logic [7:0] SIG_M      = 8'h4D;  // 'M'
  localparam logic [7:0] NUM_PLANES = 8'd1;
  localparam logic [7:0] BPP        = 8'(8 * 3);

  // One pixel request as handed to the byte sequencer.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       hdr;         // header goes out ahead of this pixel
    logic [1:0] pad;         // zero bytes after this pixel
    logic       frame_done;  // last pixel of the file
  } bss_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_BLUE,
    ST_GREEN,
    ST_RED,
    ST_PAD
  } seq_state_t;

endpackage

`default_nettype wire

/* rtl/bmp_stream_serializer.sv */
// Top level of the BMP stream serializer.
`default_nettype none

// Turns RGB pixels, given in row order, into the byte stream of a 24-bit
// uncompressed BMP file, one byte per cycle on the output channel. The first
// pixel of a frame is preceded by the 54-byte header (signature, file size,
// data offset, info header with width, height, one plane, 24 bpp); each pixel
// goes out as blue, green, red, and the last pixel of a row is followed by
// zero bytes up to a multiple of four. run_last marks the final byte of each
// pixel request and frame_end the final byte of the file. Rate: the byte
// sequencer emits one byte per cycle unless the output stalls; a pixel is 3
// bytes, plus (width mod 4) padding bytes at row end and 54 header bytes at
// frame start. A one-deep pixel register in front of the sequencer takes the
// next request while the current one is still being sent, so back-to-back
// pixels stream with no gap. Configuration (index 0 width, index 1 height)
// is to be written only while the block is idle; the block does not enforce
// it. The file size is derived from the dimensions through a registered 32x32 multiply.
module bmp_stream_serializer #(
  parameter int DIM_BITS = bss_pkg::DIM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]                cfg_data,
  // pixel requests
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  // file bytes
  output logic                               byte_valid,
  input  logic                               byte_stall,
  output logic [7:0]                         data_byte,
  output logic                               run_last,
  output logic                               frame_end
);
  import bss_pkg::*;

  logic [DIM_BITS-1:0] width;
  logic [DIM_BITS-1:0] height;
  logic [31:0]         file_size;
  logic                item_valid;
  logic                item_take;
  bss_item_t           item;

  // width/height registers and header file size
  bss_cfg_regs #(.DIM_BITS(DIM_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .width     (width),
    .height    (height),
    .file_size (file_size)
  );

  // input register; decides header, padding and frame end per pixel
  bss_frame_ctrl #(.DIM_BITS(DIM_BITS)) u_frame (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .width       (width),
    .height      (height),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  // one byte per cycle into the output register unless the output stalls
  bss_byte_seq #(.DIM_BITS(DIM_BITS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .width      (width),
    .height     (height),
    .file_size  (file_size),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire

/* rtl/bss_cfg_regs.sv */
// Dimension registers and the derived file size for the BMP header.
`default_nettype none

module bss_cfg_regs #(
  parameter int DIM_BITS = bss_pkg::DIM_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [bss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]                cfg_data,
  output logic [DIM_BITS-1:0]                width,
  output logic [DIM_BITS-1:0]                height,
  output logic [31:0]                        file_size
);
  import bss_pkg::*;

  localparam int RBW = DIM_BITS + 3;

  logic [RBW-1:0] row_bytes_full;
  logic [31:0]    row_bytes;
  logic [31:0]    data_bytes;

  // padded row = 3*w + (w mod 4)
  assign row_bytes_full = RBW'(width) + (RBW'(width) << 1) + RBW'(width[1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= DIM_BITS'(IMAGE_WIDTH_RESET);
      height <= DIM_BITS'(IMAGE_HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width  <= cfg_data;
        REG_IMAGE_HEIGHT: height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Three stages: row bytes, data bytes, then file size.
  always_ff @(posedge clk) begin
    row_bytes  <= 32'(row_bytes_full);
    data_bytes <= row_bytes * 32'(height);
    file_size  <= data_bytes + 32'(HDR_LEN);
  end

endmodule

`default_nettype wire

/* rtl/bss_frame_ctrl.sv */
// Pixel input register with row and frame position tracking.
`default_nettype none

module bss_frame_ctrl #(
  parameter int DIM_BITS = bss_pkg::DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic [DIM_BITS-1:0]   width,
  input  logic [DIM_BITS-1:0]   height,
  output logic                  item_valid,
  output bss_pkg::bss_item_t    item,
  input  logic                  item_take
);
  import bss_pkg::*;

  logic [DIM_BITS-1:0] column_count;
  logic [DIM_BITS-1:0] row_count;
  logic                accept;
  logic                row_end;
  logic                last_row;

  assign pixel_stall = item_valid && !item_take;
  assign accept      = pixel_valid && !pixel_stall;

  // count+1 compared one bit wider so an all-ones count cannot wrap
  assign row_end  = ({1'b0, column_count} + 1'b1) >= {1'b0, width};
  assign last_row = ({1'b0, row_count} + 1'b1) >= {1'b0, height};

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
        if (row_end) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + 1'b1;
        end else begin
          column_count <= column_count + 1'b1;
        end
      end else if (item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.blue       <= blue;
      item.green      <= green;
      item.red        <= red;
      item.hdr        <= (column_count == '0) && (row_count == '0);
      item.pad        <= row_end ? width[1:0] : 2'd0;
      item.frame_done <= row_end && last_row;
    end
  end

endmodule

`default_nettype wire

/* rtl/bss_byte_seq.sv */
// Byte sequencer: header, pixel bytes and row padding into the output register.
`default_nettype none

module bss_byte_seq #(
  parameter int DIM_BITS = bss_pkg::DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  bss_pkg::bss_item_t  item,
  output logic                item_take,
  input  logic [DIM_BITS-1:0] width,
  input  logic [DIM_BITS-1:0] height,
  input  logic [31:0]         file_size,
  output logic                byte_valid,
  input  logic                byte_stall,
  output logic [7:0]          data_byte,
  output logic                run_last,
  output logic                frame_end
);
  import bss_pkg::*;

  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_BITS-1:0] idx,
                                          input logic [31:0] fsize,
                                          input logic [31:0] w32,
                                          input logic [31:0] h32);
    logic [1:0]  lane;
    logic [31:0] word;
    logic [7:0]  b;
    // all 32-bit fields start at an offset of 2 mod 4
    lane = idx[1:0] - 2'd2;
    word = '0;
    b    = '0;
    if (idx >= OFS_SIZE && idx < OFS_SIZE + 4)
      word = fsize;
    else if (idx >= OFS_WIDTH && idx < OFS_WIDTH + 4)
      word = w32;
    else if (idx >= OFS_HEIGHT && idx < OFS_HEIGHT + 4)
      word = h32;
    b = word[lane*8 +: 8];
    if (idx == OFS_SIG_B)  b = SIG_B;
    if (idx == OFS_SIG_M)  b = SIG_M;
    if (idx == OFS_OFFSET) b = 8'(HDR_LEN);
    if (idx == OFS_INFO)   b = 8'(INFO_HDR_LEN);
    if (idx == OFS_PLANES) b = NUM_PLANES;
    if (idx == OFS_BPP)    b = BPP;
    return b;
  endfunction

  seq_state_t              state, state_next;
  logic [HDR_IDX_BITS-1:0] hdr_idx, hdr_idx_next;
  logic [1:0]              pad_left, pad_left_next;
  bss_item_t               cur;

  logic       adv;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_last;
  logic       emit_fend;
  seq_state_t load_state;

  assign adv        = !byte_valid || !byte_stall;
  assign load_state = item.hdr ? ST_HDR : ST_BLUE;

  // outputs
  always_comb begin
    emit      = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_fend = 1'b0;
    item_take = 1'b0;
    case (state)
      ST_IDLE: begin
        item_take = item_valid;
      end
      ST_HDR: begin
        emit      = adv;
        emit_byte = hdr_byte(hdr_idx, file_size, 32'(width), 32'(height));
      end
      ST_BLUE: begin
        emit      = adv;
        emit_byte = cur.blue;
      end
      ST_GREEN: begin
        emit      = adv;
        emit_byte = cur.green;
      end
      ST_RED: begin
        emit      = adv;
        emit_byte = cur.red;
        if (cur.pad == 2'd0) begin
          emit_last = 1'b1;
          emit_fend = cur.frame_done;
          item_take = adv && item_valid;
        end
      end
      ST_PAD: begin
        emit = adv;
        if (pad_left == 2'd1) begin
          emit_last = 1'b1;
          emit_fend = cur.frame_done;
          item_take = adv && item_valid;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next    = state;
    hdr_idx_next  = hdr_idx;
    pad_left_next = pad_left;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next   = load_state;
          hdr_idx_next = '0;
        end
      end
      ST_HDR: begin
        if (adv) begin
          if (hdr_idx == HDR_IDX_LAST) state_next = ST_BLUE;
          else hdr_idx_next = hdr_idx + 1'b1;
        end
      end
      ST_BLUE: begin
        if (adv) state_next = ST_GREEN;
      end
      ST_GREEN: begin
        if (adv) state_next = ST_RED;
      end
      ST_RED: begin
        if (adv) begin
          if (cur.pad == 2'd0) begin
            state_next   = item_valid ? load_state : ST_IDLE;
            hdr_idx_next = '0;
          end else begin
            state_next    = ST_PAD;
            pad_left_next = cur.pad;
          end
        end
      end
      ST_PAD: begin
        if (adv) begin
          if (pad_left == 2'd1) begin
            state_next   = item_valid ? load_state : ST_IDLE;
            hdr_idx_next = '0;
          end else begin
            pad_left_next = pad_left - 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) byte_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    hdr_idx  <= hdr_idx_next;
    pad_left <= pad_left_next;
    if (item_take) cur <= item;
    if (emit) begin
      data_byte <= emit_byte;
      run_last  <= emit_last;
      frame_end <= emit_fend;
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for bmp_stream_serializer: predicts every BMP file byte and checks the stream.
`timescale 1ns / 100ps

module tb;
  import bss_pkg::*;

  localparam int DIM_W = DIM_BITS_DEF;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  // BMP header constants as the file format defines them.
  localparam logic [7:0] BMP_SIG_B      = 8'h42;
  localparam logic [7:0] BMP_SIG_M      = 8'h4D;
  localparam int         BMP_HDR_BYTES  = 54;
  localparam int         BMP_INFO_BYTES = 40;
  localparam int         BMP_BPP        = 24;

  // Cycles let pass around a register write: the block derives the file size
  // from the written dimensions through a registered multiply.
  localparam int SETTLE_CYCLES = 16;
  // Cycles with no request moving on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 150;

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } file_byte_t;

  logic clk;
  logic rst = 1'b1;

  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [DIM_W-1:0]          cfg_data  = '0;

  logic       pixel_valid = 1'b0;
  logic       pixel_stall;
  logic [7:0] red   = '0;
  logic [7:0] green = '0;
  logic [7:0] blue  = '0;

  logic       byte_valid;
  logic       byte_stall = 1'b0;
  logic [7:0] data_byte;
  logic       run_last;
  logic       frame_end;

  bmp_stream_serializer #(.DIM_BITS(DIM_W)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

  // Predictor state: mirrors the dimension registers and the pixel position.
  logic [DIM_W-1:0] img_width  = DIM_W'(IMAGE_WIDTH_RESET);
  logic [DIM_W-1:0] img_height = DIM_W'(IMAGE_HEIGHT_RESET);
  logic [DIM_W-1:0] col_pos    = '0;
  logic [DIM_W-1:0] row_pos    = '0;

  file_byte_t file_bytes_q[$];  // predicted bytes not yet seen on the output
  logic [7:0] pixel_bytes[$];   // scratch: bytes caused by the pixel at hand

  int send_idle_pct = 0;  // chance per cycle that the sender holds off
  int stall_pct     = 0;  // chance per cycle that the receiver stalls
  int sent_items    = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int row_padding(input logic [DIM_W-1:0] w);
    return (4 - ((int'(w) * 3) % 4)) % 4;
  endfunction

  function automatic void add_le32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) pixel_bytes.push_back(v[8*k +: 8]);
  endfunction

  // 14-byte file header followed by the 40-byte info header.
  function automatic void add_header();
    longint row_bytes;
    logic [31:0] file_size;
    row_bytes = longint'(img_width) * 3 + row_padding(img_width);
    file_size = 32'(BMP_HDR_BYTES + row_bytes * longint'(img_height));
    pixel_bytes.push_back(BMP_SIG_B);
    pixel_bytes.push_back(BMP_SIG_M);
    add_le32(file_size);
    add_le32(32'd0);
    add_le32(32'(BMP_HDR_BYTES));
    add_le32(32'(BMP_INFO_BYTES));
    add_le32(32'(img_width));
    add_le32(32'(img_height));
    pixel_bytes.push_back(8'd1);   // planes, low byte
    pixel_bytes.push_back(8'd0);
    pixel_bytes.push_back(8'(BMP_BPP));
    pixel_bytes.push_back(8'd0);
    // compression, image size, resolution and palette fields stay zero
    repeat (24) pixel_bytes.push_back(8'd0);
  endfunction

  // Queues the bytes one pixel causes and steps the position; returns 1 when
  // the pixel closes the frame.
  function automatic bit serialize_pixel(input logic [7:0] r, g, b);
    bit row_done;
    bit frame_done;
    file_byte_t fb;
    pixel_bytes.delete();
    // header goes out with the first pixel of a frame
    if (col_pos == '0 && row_pos == '0) add_header();
    pixel_bytes.push_back(b);
    pixel_bytes.push_back(g);
    pixel_bytes.push_back(r);
    // a count at or past the bound ends the row, which covers width zero and
    // a width shrunk below the position mid-frame
    row_done   = (int'(col_pos) + 1 >= int'(img_width));
    frame_done = 1'b0;
    if (row_done) begin
      repeat (row_padding(img_width)) pixel_bytes.push_back(8'd0);
      col_pos = '0;
      if (int'(row_pos) + 1 >= int'(img_height)) begin
        row_pos    = '0;
        frame_done = 1'b1;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    foreach (pixel_bytes[k]) begin
      fb.data      = pixel_bytes[k];
      fb.run_last  = (k == pixel_bytes.size() - 1);
      fb.frame_end = fb.run_last && frame_done;
      file_bytes_q.push_back(fb);
    end
    return frame_done;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one pixel and waits for its acceptance. Valid is left high so that
  // back-to-back pixels need no second assignment within one step; whoever
  // stops sending lowers it.
  task automatic send_pixel(input logic [7:0] r, g, b, output bit frame_done);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (pixel_stall);
    frame_done = serialize_pixel(r, g, b);
    sent_items++;
  endtask

  // Write enable stays high across a run of writes; the caller drops it.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [DIM_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) img_width = value;
    else if (idx == REG_IMAGE_HEIGHT) img_height = value;
  endtask

  task automatic drain_output();
    pixel_valid <= 1'b0;
    while (file_bytes_q.size() != 0) @(posedge clk);
  endtask

  // Waits for the block to go idle, then writes both dimensions. The position
  // is kept, so a call mid-frame is a mid-frame register change.
  task automatic set_dims(input logic [DIM_W-1:0] w, h);
    drain_output();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    // now and then a write to an index with no register behind it
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_write <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic finish_frame();
    bit done;
    done = 1'b0;
    while (!done) send_pixel(8'($urandom), 8'($urandom), 8'($urandom), done);
  endtask

  function automatic logic [DIM_W-1:0] pick_width();
    if ($urandom_range(0, 11) == 0) return '0;
    return DIM_W'($urandom_range(1, 9));
  endfunction

  function automatic logic [DIM_W-1:0] pick_height();
    if ($urandom_range(0, 11) == 0) return '0;
    return DIM_W'($urandom_range(1, 3));
  endfunction

  function automatic int frame_pixels(input logic [DIM_W-1:0] w, h);
    return (w == '0 ? 1 : int'(w)) * (h == '0 ? 1 : int'(h));
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall and the byte checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    byte_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    file_byte_t want;
    if (!rst && byte_valid && !byte_stall) begin
      if (file_bytes_q.size() == 0) begin
        $error("unexpected byte %0h on the output", data_byte);
        fail_count++;
      end else begin
        want = file_bytes_q.pop_front();
        if (data_byte !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, data_byte);
          fail_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last);
          fail_count++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
          fail_count++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (byte_valid && !byte_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("bmp_stream_serializer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset dimensions 640 x 480 go into the first header; the frame is then
  // cut short by shrinking both dimensions below the current position.
  task automatic test_reset_dims();
    bit done;
    send_pixel(8'h00, 8'h00, 8'h00, done);
    send_pixel(8'hFF, 8'hFF, 8'hFF, done);
    send_pixel(8'hA5, 8'h5A, 8'hC3, done);
    set_dims(DIM_W'(1), DIM_W'(1));
    finish_frame();
  endtask

  // Largest dimensions in the header, then a mid-frame shrink of the width
  // and later of the height so the frame ends early without a new header.
  task automatic test_max_dims();
    bit done;
    set_dims({DIM_W{1'b1}}, {DIM_W{1'b1}});
    send_pixel(8'h12, 8'h34, 8'h56, done);
    send_pixel(8'hFE, 8'h01, 8'h80, done);
    set_dims(DIM_W'(1), {DIM_W{1'b1}});
    send_pixel(8'h7F, 8'h80, 8'h01, done);
    set_dims(DIM_W'(1), DIM_W'(1));
    finish_frame();
  endtask

  // Width zero ends every row, height zero every frame; both show as 0 in
  // the header.
  task automatic test_zero_dims();
    set_dims('0, '0);
    repeat (3) finish_frame();
    set_dims('0, DIM_W'(2));
    finish_frame();
  endtask

  // Writes to the two spare indexes must leave the dimensions alone.
  task automatic test_spare_index();
    set_dims(DIM_W'(3), DIM_W'(1));
    drain_output();
    write_reg(REG_SPARE_A, {DIM_W{1'b1}});
    write_reg(REG_SPARE_B, '0);
    cfg_write <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    finish_frame();
  endtask

  // Widths 1..4 give row padding of 1, 2, 3 and 0 bytes.
  task automatic test_row_padding();
    for (int w = 1; w <= 4; w++) begin
      set_dims(DIM_W'(w), DIM_W'(1));
      finish_frame();
    end
  endtask

  // Mostly small complete frames; some frames get a dimension change part
  // way through, and some start at random dimensions of any size and are
  // shrunk after a pixel or three to keep the run short.
  task automatic test_random_frames(input int sender_pct, input int receiver_pct);
    int stop_at;
    int lead;
    bit done;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
    stop_at       = sent_items + RANDOM_PER_PHASE;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        w = DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
        h = DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
      end else begin
        w = pick_width();
        h = pick_height();
      end
      set_dims(w, h);
      done = 1'b0;
      if (frame_pixels(w, h) > 40 || $urandom_range(0, 5) == 0) begin
        lead = $urandom_range(1, 3);
        while (!done && lead > 0) begin
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom), done);
          lead--;
        end
        if (!done) set_dims(pick_width(), pick_height());
      end
      if (!done) finish_frame();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs with the sender idling lightly and the receiver often
    send_idle_pct = 25;
    stall_pct     = 56;
    test_reset_dims();
    test_max_dims();
    test_zero_dims();
    test_spare_index();
    test_row_padding();

    test_random_frames(25, 56);
    test_random_frames(56, 25);
    test_random_frames(0, 0);

    drain_output();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bmp_stream_serializer verification clean");
    end else begin
      $display("bmp_stream_serializer verification failed");
    end
    $finish;
  end

endmodule

/* bmp_stream_serializer.f */
rtl/bss_pkg.sv
rtl/bss_cfg_regs.sv
rtl/bss_frame_ctrl.sv
rtl/bss_byte_seq.sv
rtl/bmp_stream_serializer.sv
tb/tb.sv
